// File: hdl/rct_pkg.sv
package rct_pkg;

    localparam int VW      = 32;
    localparam int MAX_LEN = 1024;
    localparam int LEVELS  = 10;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_MOD  = 2'd1;
    localparam logic [1:0] CFG_LEN  = 2'd2;

    localparam logic          MODE_RST = 1'b1;
    localparam logic [VW-1:0] MOD_RST  = 32'd1000000007;
    localparam logic [10:0]   LEN_RST  = 11'd1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_UNBUILT = 2'd2;

    localparam logic [1:0] Q_ERR = 2'd0;
    localparam logic [1:0] Q_ONE = 2'd1;
    localparam logic [1:0] Q_TWO = 2'd2;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE     = 5'd0;
    localparam t_op OP_LVL_INIT = 5'd1;
    localparam t_op OP_LVL_NEXT = 5'd2;
    localparam t_op OP_BLK      = 5'd3;
    localparam t_op OP_SEED_S   = 5'd4;
    localparam t_op OP_SUF_RD   = 5'd5;
    localparam t_op OP_SUF_GO   = 5'd6;
    localparam t_op OP_SUF_WR   = 5'd7;
    localparam t_op OP_PRE      = 5'd8;
    localparam t_op OP_SEED_P   = 5'd9;
    localparam t_op OP_PRE_RD   = 5'd10;
    localparam t_op OP_PRE_GO   = 5'd11;
    localparam t_op OP_PRE_WR   = 5'd12;
    localparam t_op OP_BLK_NEXT = 5'd13;
    localparam t_op OP_BUILT    = 5'd14;
    localparam t_op OP_Q_ERR    = 5'd15;
    localparam t_op OP_Q_ONE    = 5'd16;
    localparam t_op OP_Q_ONE_D  = 5'd17;
    localparam t_op OP_Q_TWO    = 5'd18;
    localparam t_op OP_Q_A      = 5'd19;
    localparam t_op OP_Q_B      = 5'd20;
    localparam t_op OP_Q_W      = 5'd21;
    localparam t_op OP_OUT      = 5'd22;

    typedef struct packed {
        logic       lvl_done;
        logic       blk_done;
        logic       suf_more;
        logic       t_end;
        logic       pre_more;
        logic       alu_done;
        logic       out_free;
        logic [1:0] q_class;
    } t_sts;

endpackage

// File: hdl/rct_ram.sv
module rct_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

// File: hdl/rct_alu.sv
module rct_alu import rct_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_mode,
    input  logic [VW-1:0] i_mod,
    input  logic [VW-1:0] i_a,
    input  logic [VW-1:0] i_b,
    output logic          o_done,
    output logic [VW-1:0] o_result
);

    localparam int CW = $clog2(VW);
    localparam int KW = $clog2(VW) + 1;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_RED  = 3'd1;
    localparam logic [2:0] A_MUL  = 3'd2;
    localparam logic [2:0] A_GCD  = 3'd3;
    localparam logic [2:0] A_DONE = 3'd4;

    logic [2:0]    r_st;
    logic [VW-1:0] r_x;
    logic [VW-1:0] r_y;
    logic [VW:0]   r_r;
    logic [VW-1:0] r_am;
    logic [VW-1:0] r_m;
    logic [CW-1:0] r_cnt;
    logic [KW-1:0] r_k;
    logic [VW-1:0] r_res;

    logic [VW:0] red_t, red_v, mul_t, mul_d, mul_u, mul_v, m_ext;

    assign m_ext = {1'b0, r_m};

    always_comb begin
        red_t = {r_r[VW-1:0], r_x[VW-1]};
        red_v = (red_t >= m_ext) ? red_t - m_ext : red_t;
        mul_t = {r_r[VW-1:0], 1'b0};
        mul_d = (mul_t >= m_ext) ? mul_t - m_ext : mul_t;
        mul_u = r_y[VW-1] ? mul_d + {1'b0, r_am} : mul_d;
        mul_v = (mul_u >= m_ext) ? mul_u - m_ext : mul_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            unique case (r_st)
                A_IDLE: begin
                    if (i_start) begin
                        r_x   <= i_a;
                        r_y   <= i_b;
                        r_r   <= '0;
                        r_cnt <= '0;
                        r_k   <= '0;
                        r_m   <= (i_mod == '0) ? VW'(1) : i_mod;
                        r_st  <= i_mode ? A_RED : A_GCD;
                    end
                end
                A_RED: begin
                    r_r   <= red_v;
                    r_x   <= r_x << 1;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(VW - 1)) begin
                        r_am  <= red_v[VW-1:0];
                        r_r   <= '0;
                        r_cnt <= '0;
                        r_st  <= A_MUL;
                    end
                end
                A_MUL: begin
                    r_r   <= mul_v;
                    r_y   <= r_y << 1;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(VW - 1)) begin
                        r_res <= mul_v[VW-1:0];
                        r_st  <= A_DONE;
                    end
                end
                A_GCD: begin
                    if (r_x == '0) begin
                        r_res <= r_y << r_k;
                        r_st  <= A_DONE;
                    end else if (r_y == '0) begin
                        r_res <= r_x << r_k;
                        r_st  <= A_DONE;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x >= r_y) begin
                        r_x <= (r_x - r_y) >> 1;
                    end else begin
                        r_y <= (r_y - r_x) >> 1;
                    end
                end
                A_DONE: begin
                    r_st <= A_IDLE;
                end
                default: begin
                    r_st <= A_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_st == A_DONE);
    assign o_result = r_res;

endmodule

// File: hdl/rct_dp.sv
module rct_dp import rct_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_op           i_op,
    input  logic          i_in_acc,
    input  logic          i_command,
    input  logic [9:0]    i_elem_index,
    input  logic [VW-1:0] i_elem_value,
    input  logic [9:0]    i_range_left,
    input  logic [10:0]   i_range_right,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_out_stall,
    output t_sts          o_sts,
    output logic          o_out_valid,
    output logic [VW-1:0] o_answer,
    output logic [1:0]    o_status
);

    localparam int IW     = $clog2(MAX_LEN);
    localparam int NW     = $clog2(MAX_LEN + 1);
    localparam int XW     = NW + 2;
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LCW    = $clog2(LEVELS + 1);
    localparam int AW     = LW + IW;
    localparam int DEPTH  = LEVELS * (2 ** IW);

    logic          r_mode;
    logic [VW-1:0] r_mod;
    logic [10:0]   r_len;
    logic          r_built;
    logic [LCW-1:0] r_lvl;
    logic [XW-1:0] r_j;
    logic [NW-1:0] r_t, r_e, r_k;
    logic [VW-1:0] r_acc, r_qa, r_res;
    logic [1:0]    r_rst;
    logic [9:0]    r_left;
    logic [10:0]   r_right;
    logic [LW-1:0] r_lv;
    logic          r_ov;
    logic [VW-1:0] r_answer;
    logic [1:0]    r_status;

    logic [NW-1:0] len_n, s_n, t_val, e_val;
    logic [31:0]   s_full;
    logic [XW-1:0] sum_js, sum_ts;
    logic [10:0]   last;
    logic [10:0]   xd;
    logic [3:0]    lv;
    logic [1:0]    q_class, q_code;
    logic [LW-1:0] lvl_a;
    logic          out_free;

    logic          we;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [VW-1:0] wr_data, rd_data;
    logic          alu_go, alu_done;
    logic [VW-1:0] alu_a, alu_b, alu_res;

    always_comb begin
        if (r_len == '0) begin
            len_n = NW'(1);
        end else if (32'(r_len) > MAX_LEN) begin
            len_n = NW'(MAX_LEN);
        end else begin
            len_n = NW'(r_len);
        end
        s_full = 32'd1 << r_lvl;
        s_n    = s_full[NW-1:0];
        sum_js = r_j + XW'(s_n);
        sum_ts = XW'(r_t) + XW'(s_n);
        t_val  = (sum_js < XW'(len_n)) ? sum_js[NW-1:0] : len_n;
        e_val  = (sum_ts < XW'(len_n)) ? sum_ts[NW-1:0] : len_n;
        lvl_a  = r_lvl[LW-1:0];
    end

    always_comb begin
        last = r_right - 11'd1;
        xd   = {1'b0, r_left} ^ last;
        lv   = '0;
        for (int i = 0; i < 11; i++) begin
            if (xd[i]) lv = 4'(i);
        end
        q_class = Q_TWO;
        q_code  = ST_OK;
        if (!r_built) begin
            q_class = Q_ERR;
            q_code  = ST_UNBUILT;
        end else if (32'(r_left) >= 32'(len_n) || 32'(r_right) > 32'(len_n)) begin
            q_class = Q_ERR;
            q_code  = ST_RANGE;
        end else if (r_right == '0 || {1'b0, r_left} >= last) begin
            q_class = Q_ONE;
        end else if (32'(lv) >= LEVELS) begin
            q_class = Q_ERR;
            q_code  = ST_RANGE;
        end
    end

    assign out_free = !r_ov || !i_out_stall;

    always_comb begin
        we      = i_in_acc && (i_command == CMD_LOAD) && (32'(i_elem_index) < MAX_LEN);
        wr_addr = {LW'(0), IW'(i_elem_index)};
        wr_data = i_elem_value;
        rd_addr = '0;
        alu_go  = 1'b0;
        alu_a   = r_acc;
        alu_b   = rd_data;
        unique case (i_op)
            OP_BLK:    rd_addr = {LW'(0), IW'(t_val - NW'(1))};
            OP_SEED_S: begin
                we      = 1'b1;
                wr_addr = {lvl_a, r_k[IW-1:0]};
                wr_data = rd_data;
            end
            OP_SUF_RD: rd_addr = {LW'(0), IW'(r_k - NW'(1))};
            OP_SUF_GO: begin
                alu_go = 1'b1;
                alu_a  = rd_data;
                alu_b  = r_acc;
            end
            OP_SUF_WR: begin
                we      = 1'b1;
                wr_addr = {lvl_a, IW'(r_k - NW'(1))};
                wr_data = alu_res;
            end
            OP_PRE:    rd_addr = {LW'(0), r_t[IW-1:0]};
            OP_SEED_P: begin
                we      = 1'b1;
                wr_addr = {lvl_a, r_t[IW-1:0]};
                wr_data = rd_data;
            end
            OP_PRE_RD: rd_addr = {LW'(0), r_k[IW-1:0]};
            OP_PRE_GO: alu_go = 1'b1;
            OP_PRE_WR: begin
                we      = 1'b1;
                wr_addr = {lvl_a, r_k[IW-1:0]};
                wr_data = alu_res;
            end
            OP_Q_ONE:  rd_addr = {LW'(0), IW'(r_left)};
            OP_Q_TWO:  rd_addr = {LW'(lv), IW'(r_left)};
            OP_Q_A:    rd_addr = {r_lv, IW'(last)};
            OP_Q_B: begin
                alu_go = 1'b1;
                alu_a  = r_qa;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RST;
            r_mod   <= MOD_RST;
            r_len   <= LEN_RST;
            r_built <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODE: begin
                        r_mode  <= i_cfg_data[0];
                        r_built <= 1'b0;
                    end
                    CFG_MOD: begin
                        r_mod   <= i_cfg_data;
                        r_built <= 1'b0;
                    end
                    CFG_LEN: begin
                        r_len   <= i_cfg_data[10:0];
                        r_built <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_in_acc) begin
                r_left  <= i_range_left;
                r_right <= i_range_right;
                if (i_command == CMD_LOAD) begin
                    r_built <= 1'b0;
                end
            end
            if (i_op == OP_OUT) begin
                r_ov     <= 1'b1;
                r_answer <= r_res;
                r_status <= r_rst;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (i_op) inside
                OP_LVL_INIT: begin
                    r_lvl <= LCW'(1);
                    r_j   <= '0;
                end
                OP_LVL_NEXT: begin
                    r_lvl <= r_lvl + LCW'(1);
                    r_j   <= '0;
                end
                OP_BLK: begin
                    r_t <= t_val;
                    r_k <= t_val - NW'(1);
                end
                OP_SEED_S, OP_SEED_P: r_acc <= rd_data;
                OP_SUF_WR: begin
                    r_acc <= alu_res;
                    r_k   <= r_k - NW'(1);
                end
                OP_PRE: begin
                    r_k <= r_t + NW'(1);
                    r_e <= e_val;
                end
                OP_PRE_WR: begin
                    r_acc <= alu_res;
                    r_k   <= r_k + NW'(1);
                end
                OP_BLK_NEXT: r_j <= r_j + (XW'(s_n) << 1);
                OP_BUILT:    r_built <= 1'b1;
                OP_Q_ERR: begin
                    r_res <= '0;
                    r_rst <= q_code;
                end
                OP_Q_ONE_D: begin
                    r_res <= rd_data;
                    r_rst <= ST_OK;
                end
                OP_Q_TWO:    r_lv <= LW'(lv);
                OP_Q_A:      r_qa <= rd_data;
                OP_Q_W: begin
                    r_res <= alu_res;
                    r_rst <= ST_OK;
                end
                default: ;
            endcase
        end
    end

    rct_ram #(
        .WIDTH  (VW),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rct_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (alu_go),
        .i_mode   (r_mode),
        .i_mod    (r_mod),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    always_comb begin
        o_sts.lvl_done = (32'(r_lvl) >= LEVELS) || (s_full >= 32'(len_n));
        o_sts.blk_done = r_j >= XW'(len_n);
        o_sts.suf_more = XW'(r_k) > r_j;
        o_sts.t_end    = r_t >= len_n;
        o_sts.pre_more = r_k < r_e;
        o_sts.alu_done = alu_done;
        o_sts.out_free = out_free;
        o_sts.q_class  = q_class;
    end

    assign o_out_valid = r_ov;
    assign o_answer    = r_answer;
    assign o_status    = r_status;

endmodule

// File: hdl/rct_ctrl.sv
module rct_ctrl import rct_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_acc,
    input  logic i_command,
    input  logic i_is_last,
    input  t_sts i_sts,
    output t_op  o_op,
    output logic o_busy
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_LVL_INIT = 5'd1;
    localparam logic [4:0] S_LVL_CHK  = 5'd2;
    localparam logic [4:0] S_BLK      = 5'd3;
    localparam logic [4:0] S_SEED_S   = 5'd4;
    localparam logic [4:0] S_SUF_CHK  = 5'd5;
    localparam logic [4:0] S_SUF_GO   = 5'd6;
    localparam logic [4:0] S_SUF_W    = 5'd7;
    localparam logic [4:0] S_PRE      = 5'd8;
    localparam logic [4:0] S_SEED_P   = 5'd9;
    localparam logic [4:0] S_PRE_CHK  = 5'd10;
    localparam logic [4:0] S_PRE_GO   = 5'd11;
    localparam logic [4:0] S_PRE_W    = 5'd12;
    localparam logic [4:0] S_LVL_NEXT = 5'd13;
    localparam logic [4:0] S_BUILT    = 5'd14;
    localparam logic [4:0] S_Q        = 5'd15;
    localparam logic [4:0] S_Q_ONE    = 5'd16;
    localparam logic [4:0] S_Q_A      = 5'd17;
    localparam logic [4:0] S_Q_B      = 5'd18;
    localparam logic [4:0] S_Q_W      = 5'd19;
    localparam logic [4:0] S_OUT      = 5'd20;

    logic [4:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_acc) begin
                    if (i_command == CMD_QUERY) n_state = S_Q;
                    else if (i_is_last) n_state = S_LVL_INIT;
                end
            end
            S_LVL_INIT: begin
                o_op    = OP_LVL_INIT;
                n_state = S_LVL_CHK;
            end
            S_LVL_CHK: n_state = i_sts.lvl_done ? S_BUILT : S_BLK;
            S_BLK: begin
                if (i_sts.blk_done) begin
                    n_state = S_LVL_NEXT;
                end else begin
                    o_op    = OP_BLK;
                    n_state = S_SEED_S;
                end
            end
            S_SEED_S: begin
                o_op    = OP_SEED_S;
                n_state = S_SUF_CHK;
            end
            S_SUF_CHK: begin
                if (i_sts.suf_more) begin
                    o_op    = OP_SUF_RD;
                    n_state = S_SUF_GO;
                end else begin
                    n_state = S_PRE;
                end
            end
            S_SUF_GO: begin
                o_op    = OP_SUF_GO;
                n_state = S_SUF_W;
            end
            S_SUF_W: begin
                if (i_sts.alu_done) begin
                    o_op    = OP_SUF_WR;
                    n_state = S_SUF_CHK;
                end
            end
            S_PRE: begin
                if (i_sts.t_end) begin
                    n_state = S_LVL_NEXT;
                end else begin
                    o_op    = OP_PRE;
                    n_state = S_SEED_P;
                end
            end
            S_SEED_P: begin
                o_op    = OP_SEED_P;
                n_state = S_PRE_CHK;
            end
            S_PRE_CHK: begin
                if (i_sts.pre_more) begin
                    o_op    = OP_PRE_RD;
                    n_state = S_PRE_GO;
                end else begin
                    o_op    = OP_BLK_NEXT;
                    n_state = S_BLK;
                end
            end
            S_PRE_GO: begin
                o_op    = OP_PRE_GO;
                n_state = S_PRE_W;
            end
            S_PRE_W: begin
                if (i_sts.alu_done) begin
                    o_op    = OP_PRE_WR;
                    n_state = S_PRE_CHK;
                end
            end
            S_LVL_NEXT: begin
                o_op    = OP_LVL_NEXT;
                n_state = S_LVL_CHK;
            end
            S_BUILT: begin
                o_op    = OP_BUILT;
                n_state = S_IDLE;
            end
            S_Q: begin
                unique case (i_sts.q_class)
                    Q_ONE: begin
                        o_op    = OP_Q_ONE;
                        n_state = S_Q_ONE;
                    end
                    Q_TWO: begin
                        o_op    = OP_Q_TWO;
                        n_state = S_Q_A;
                    end
                    default: begin
                        o_op    = OP_Q_ERR;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_Q_ONE: begin
                o_op    = OP_Q_ONE_D;
                n_state = S_OUT;
            end
            S_Q_A: begin
                o_op    = OP_Q_A;
                n_state = S_Q_B;
            end
            S_Q_B: begin
                o_op    = OP_Q_B;
                n_state = S_Q_W;
            end
            S_Q_W: begin
                if (i_sts.alu_done) begin
                    o_op    = OP_Q_W;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: hdl/range_combine_table.sv
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_stall    i_command, i_elem_index, i_elem_value,
//                                                i_is_last, i_range_left, i_range_right
// out      output     o_out_valid / i_out_stall  o_answer, o_status
// cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// A load writes its element into level 0 when it is accepted. A query reads up to
// two table entries and, when it needs two, runs one combine: product mode does a
// 32-step reduce, a 32-step shift-add multiply and a done state; gcd mode runs
// binary-gcd steps until one operand is zero. The final load builds the table over
// n*log2(n) entries, each a read and at most one combine; o_in_stall is held meanwhile.
// Reset is synchronous; the table memory is not cleared. The result word sits
// in an output register; a stalled output holds a finished query in place.
module range_combine_table import rct_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_command,
    input  logic [9:0]    i_elem_index,
    input  logic [VW-1:0] i_elem_value,
    input  logic          i_is_last,
    input  logic [9:0]    i_range_left,
    input  logic [10:0]   i_range_right,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [VW-1:0] o_answer,
    output logic [1:0]    o_status,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    t_op  op;
    t_sts sts;
    logic busy;
    logic in_acc;

    assign in_acc     = i_in_valid && !busy;
    assign o_in_stall = busy;

    rct_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_acc  (in_acc),
        .i_command (i_command),
        .i_is_last (i_is_last),
        .i_sts     (sts),
        .o_op      (op),
        .o_busy    (busy)
    );

    rct_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .i_in_acc      (in_acc),
        .i_command     (i_command),
        .i_elem_index  (i_elem_index),
        .i_elem_value  (i_elem_value),
        .i_range_left  (i_range_left),
        .i_range_right (i_range_right),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_answer      (o_answer),
        .o_status      (o_status)
    );

endmodule

// File: tb/sv/tb_range_combine_table.sv
module tb_range_combine_table import rct_pkg::*;;

    localparam int TBL_LEN = 1024;
    localparam int TBL_LVL = 10;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cidx;
        logic [31:0] cdata;
        logic        cmd;
        logic [9:0]  idx;
        logic [31:0] val;
        logic        last;
        logic [9:0]  lft;
        logic [10:0] rgt;
        bit          typed;
        logic [31:0] t_ans;
        logic [1:0]  t_st;
    } t_row;

    typedef struct {
        logic [31:0] ans;
        logic [1:0]  st;
    } t_word;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    logic          i_command = CMD_LOAD;
    logic [9:0]    i_elem_index = '0;
    logic [VW-1:0] i_elem_value = '0;
    logic          i_is_last = 1'b0;
    logic [9:0]    i_range_left = '0;
    logic [10:0]   i_range_right = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    logic [VW-1:0] o_answer;
    logic [1:0]    o_status;
    logic          i_cfg_we = 1'b0;
    logic [1:0]    i_cfg_index = CFG_MODE;
    logic [31:0]   i_cfg_data = '0;

    range_combine_table u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow state
    logic        sh_mode;
    logic [31:0] sh_mod;
    logic [10:0] sh_len;
    bit          sh_built;
    logic [31:0] sh_tbl [0:TBL_LVL-1][0:TBL_LEN-1];
    bit          sh_written [0:TBL_LEN-1];

    t_word answers_q[$];
    t_row  rows[$];
    int    errors = 0;
    int    gcd_factor = 6;

    function automatic int eff_len();
        if (sh_len == 0) return 1;
        if (sh_len > TBL_LEN) return TBL_LEN;
        return int'(sh_len);
    endfunction

    function automatic logic [31:0] combine_vals(logic [31:0] a, logic [31:0] b);
        logic [63:0] x, y, t, m;
        if (sh_mode == 1'b0) begin
            x = 64'(a);
            y = 64'(b);
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x[31:0];
        end
        m = (sh_mod == 0) ? 64'd1 : {32'd0, sh_mod};
        x = ((64'(a) % m) * (64'(b) % m)) % m;
        return x[31:0];
    endfunction

    function automatic void build_levels();
        int n, s, j, t, e, k;
        n = eff_len();
        for (int i = 1; i < TBL_LVL; i++) begin
            s = 1 << i;
            if (s >= n) break;
            for (j = 0; j < n; j += 2 * s) begin
                t = (j + s < n) ? j + s : n;
                sh_tbl[i][t-1] = sh_tbl[0][t-1];
                for (k = t - 1; k > j; k--)
                    sh_tbl[i][k-1] = combine_vals(sh_tbl[0][k-1], sh_tbl[i][k]);
                if (t >= n) break;
                sh_tbl[i][t] = sh_tbl[0][t];
                e = (t + s < n) ? t + s : n;
                for (k = t + 1; k < e; k++)
                    sh_tbl[i][k] = combine_vals(sh_tbl[i][k-1], sh_tbl[0][k]);
            end
        end
        sh_built = 1;
    endfunction

    task automatic predict_word(input t_row r, output bit has, output t_word w);
        int n, lv;
        logic [10:0] lst, x;
        has = 0;
        w.ans = '0;
        w.st = ST_OK;
        if (r.cmd == CMD_LOAD) begin
            sh_built = 0;
            sh_tbl[0][r.idx] = r.val;
            sh_written[r.idx] = 1;
            if (r.last) build_levels();
            return;
        end
        has = 1;
        n = eff_len();
        if (!sh_built) begin
            w.st = ST_UNBUILT;
        end else if (r.lft >= n || r.rgt > n) begin
            w.st = ST_RANGE;
        end else if (r.rgt == 0 || r.lft >= r.rgt - 1) begin
            w.ans = sh_tbl[0][r.lft];
        end else begin
            lst = 11'(r.rgt - 1);
            x = {1'b0, r.lft} ^ lst;
            lv = 0;
            while ((x >> 1) != 0) begin
                x = x >> 1;
                lv++;
            end
            w.ans = combine_vals(sh_tbl[lv][r.lft], sh_tbl[lv][lst]);
        end
    endtask

    task automatic wait_idle();
        wait (answers_q.size() == 0);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_in_valid <= 1'b0;
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE: sh_mode = data[0];
            CFG_MOD:  sh_mod = data;
            CFG_LEN:  sh_len = data[10:0];
            default: ;
        endcase
        sh_built = 0;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_word(input t_row r);
        bit    has;
        t_word w;
        int    g;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= r.cmd;
        i_elem_index <= r.idx;
        i_elem_value <= r.val;
        i_is_last <= r.last;
        i_range_left <= r.lft;
        i_range_right <= r.rgt;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(r, has, w);
        if (has) begin
            if (r.typed) begin
                w.ans = r.t_ans;
                w.st = r.t_st;
            end
            answers_q.push_back(w);
        end
    endtask

    function automatic t_row mk_load(int idx, logic [31:0] val, bit last);
        t_row r;
        r = '{default: '0};
        r.cmd = CMD_LOAD;
        r.idx = 10'(idx);
        r.val = val;
        r.last = last;
        r.lft = 10'($urandom);
        r.rgt = 11'($urandom);
        return r;
    endfunction

    function automatic t_row mk_query(int l, int rr);
        t_row r;
        r = '{default: '0};
        r.cmd = CMD_QUERY;
        r.idx = 10'($urandom);
        r.val = $urandom;
        r.last = 1'($urandom);
        r.lft = 10'(l);
        r.rgt = 11'(rr);
        return r;
    endfunction

    function automatic t_row mk_typed(int l, int rr, logic [31:0] a, logic [1:0] st);
        t_row r;
        r = mk_query(l, rr);
        r.typed = 1;
        r.t_ans = a;
        r.t_st = st;
        return r;
    endfunction

    function automatic t_row mk_cfg(logic [1:0] idx, logic [31:0] data);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1;
        r.cidx = idx;
        r.cdata = data;
        return r;
    endfunction

    function automatic logic [31:0] rand_val();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'd0;
        if (r == 1) return 32'hFFFF_FFFF;
        if (sh_mode == 1'b0 && r > 4) return 32'($urandom_range(1, 50) * gcd_factor);
        return $urandom;
    endfunction

    task automatic load_all(int n);
        int order[$];
        int j, tmp;
        for (int i = 0; i < n; i++) order.push_back(i);
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < n; i++)
            send_word(mk_load(order[i], rand_val(), i == n - 1));
    endtask

    function automatic bit all_written(int n);
        for (int i = 0; i < n; i++)
            if (!sh_written[i]) return 0;
        return 1;
    endfunction

    task automatic random_phase(int budget);
        int n, cnt, r, k;
        t_row q;
        n = eff_len();
        cnt = 0;
        while (cnt < budget) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                load_all(n);
                k = $urandom_range(3, 8);
                for (int i = 0; i < k; i++)
                    send_word(mk_query($urandom_range(0, n - 1), $urandom_range(0, n)));
                cnt += n + k;
            end else if (r == 7) begin
                k = $urandom_range(0, TBL_LEN - 1);
                send_word(mk_load(k, rand_val(),
                                  ($urandom_range(0, 1) == 1) && all_written(n)));
                cnt++;
            end else if (r == 8) begin
                q = mk_query($urandom_range(0, TBL_LEN - 1), $urandom_range(0, TBL_LEN));
                send_word(q);
                cnt++;
            end else begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    send_word(mk_load($urandom_range(0, n - 1), rand_val(), 1'b0));
                send_word(mk_query($urandom_range(0, n - 1), $urandom_range(0, n)));
                cnt += k + 1;
            end
        end
        send_word(mk_query($urandom_range(0, n - 1), $urandom_range(0, n)));
    endtask

    // output side stall pattern
    int  stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            if ($urandom_range(0, 19) == 0) begin
                stall_left <= $urandom_range(50, 300);
                i_out_stall <= 1'b0;
            end else begin
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(1, 3);
                i_out_stall <= 1'($urandom_range(0, 1));
            end
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_q.size() == 0) begin
                $display("%0t: unexpected word answer=%h status=%0d", $time, o_answer,
                         o_status);
                errors++;
            end else begin
                if (o_answer !== answers_q[0].ans) begin
                    $display("%0t: answer expected %h actual %h", $time,
                             answers_q[0].ans, o_answer);
                    errors++;
                end
                if (o_status !== answers_q[0].st) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             answers_q[0].st, o_status);
                    errors++;
                end
                void'(answers_q.pop_front());
            end
        end
    end

    initial begin
        #(12 * 8_000_000);
        $display("range_combine_table test failed");
        $finish;
    end

    initial begin
        sh_mode = MODE_RST;
        sh_mod = MOD_RST;
        sh_len = LEN_RST;
        sh_built = 0;
        for (int i = 0; i < TBL_LEN; i++) sh_written[i] = 0;

        rows.push_back(mk_typed(0, 0, 32'd0, ST_UNBUILT));
        rows.push_back(mk_cfg(CFG_LEN, 32'd4));
        rows.push_back(mk_load(0, 32'hFFFF_FFFF, 1'b0));
        rows.push_back(mk_load(1, 32'd2, 1'b0));
        rows.push_back(mk_load(2, 32'd3, 1'b0));
        rows.push_back(mk_load(3, 32'd5, 1'b1));
        rows.push_back(mk_query(0, 4));
        rows.push_back(mk_query(1, 3));
        rows.push_back(mk_typed(3, 3, 32'd5, ST_OK));
        rows.push_back(mk_typed(2, 1, 32'd3, ST_OK));
        rows.push_back(mk_typed(0, 5, 32'd0, ST_RANGE));
        rows.push_back(mk_typed(4, 4, 32'd0, ST_RANGE));
        rows.push_back(mk_load(1, 32'd7, 1'b0));
        rows.push_back(mk_typed(0, 2, 32'd0, ST_UNBUILT));
        rows.push_back(mk_cfg(CFG_MODE, 32'd0));
        rows.push_back(mk_cfg(CFG_LEN, 32'd0));
        rows.push_back(mk_load(0, 32'd0, 1'b1));
        rows.push_back(mk_typed(0, 1, 32'd0, ST_OK));
        rows.push_back(mk_typed(0, 0, 32'd0, ST_OK));
        rows.push_back(mk_cfg(CFG_MODE, 32'd1));
        rows.push_back(mk_cfg(CFG_MOD, 32'd0));
        rows.push_back(mk_cfg(CFG_LEN, 32'd3));
        rows.push_back(mk_load(0, 32'd9, 1'b0));
        rows.push_back(mk_load(1, 32'hDEAD_BEEF, 1'b0));
        rows.push_back(mk_load(2, 32'd4, 1'b1));
        rows.push_back(mk_typed(0, 3, 32'd0, ST_OK));
        rows.push_back(mk_typed(1, 2, 32'hDEAD_BEEF, ST_OK));
        rows.push_back(mk_query(0, 2));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_reg(rows[i].cidx, rows[i].cdata);
            else send_word(rows[i]);
        end

        for (int p = 0; p < 11; p++) begin
            write_reg(CFG_MODE, 32'(p % 2));
            case (p % 6)
                0: write_reg(CFG_MOD, MOD_RST);
                1: write_reg(CFG_MOD, 32'hFFFF_FFFF);
                2: write_reg(CFG_MOD, 32'd1);
                3: write_reg(CFG_MOD, 32'd97);
                4: write_reg(CFG_MOD, 32'd0);
                default: write_reg(CFG_MOD, $urandom);
            endcase
            gcd_factor = (p % 3 == 0) ? 6 : (p % 3 == 1) ? 35 : 1024;
            write_reg(CFG_LEN, (p == 3) ? 32'd1 : 32'($urandom_range(2, 24)));
            random_phase(10);
        end

        // full-size table, length register beyond range
        write_reg(CFG_MODE, 32'd0);
        write_reg(CFG_LEN, 32'd1024);
        write_reg(CFG_LEN, 32'h7FF);
        gcd_factor = 12;
        load_all(TBL_LEN);
        send_word(mk_query(0, 1024));
        send_word(mk_query(1023, 1024));
        send_word(mk_query(511, 513));
        send_word(mk_query(0, 1025));
        for (int i = 0; i < 40; i++)
            send_word(mk_query($urandom_range(0, TBL_LEN - 1), $urandom_range(0, TBL_LEN)));

        i_in_valid <= 1'b0;
        wait_idle();
        if (errors == 0 && answers_q.size() == 0) begin
            $display("range_combine_table test passed");
        end else begin
            $display("range_combine_table test failed");
        end
        $finish;
    end

endmodule
